// File: rtl/bilinear_density_ordered_dither_defines.svh
// Assertion macros used by the divider (bdod_div) of the bilinear density dither RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BILINEAR_DENSITY_ORDERED_DITHER_DEFINES_SVH
`define BILINEAR_DENSITY_ORDERED_DITHER_DEFINES_SVH

// Condition on one edge implies a condition on the same edge.
`define BDOD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define BDOD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdod_pkg.sv
// Shared constants, types and helper functions of the bilinear density dither.
// No dependencies; the other RTL files, apart from the macros header, refer to it by scoped names.
package bdod_pkg;

  localparam int unsigned PosW   = 6;
  localparam int unsigned ShiftW = 4;
  localparam int unsigned AlphaW = 4;
  localparam int unsigned LevelW = 8;
  localparam int unsigned DvdW   = 21;  // 2*num + den
  localparam int unsigned DvsW   = 13;  // 2*den

  localparam logic [PosW-1:0] MaxGrid   = 6'd63;
  localparam logic [PosW-1:0] GridReset = 6'd10;

  // 4x4 magic matrix, row-major
  localparam logic [3:0] Magic4 [16] = '{
    4'd0,  4'd14, 4'd3,  4'd13,
    4'd11, 4'd5,  4'd8,  4'd6,
    4'd12, 4'd2,  4'd15, 4'd1,
    4'd7,  4'd9,  4'd4,  4'd10
  };

  // Request leaving the front end toward the divider
  typedef struct packed {
    logic [DvdW-1:0]   dvd;
    logic [DvsW-1:0]   dvs;
    logic [LevelW-1:0] thr;
  } front_t;

  // Request leaving the divider
  typedef struct packed {
    logic [LevelW-1:0] quo;
    logic [LevelW-1:0] thr;
  } quot_t;

  // Two-level ordered dither threshold at (col,row)
  function automatic logic [LevelW-1:0] dither_thr(logic [3:0] col, logic [3:0] row);
    logic [3:0]  m_ij;
    logic [3:0]  m_kl;
    logic [14:0] t;
    m_ij = Magic4[{col[1:0], row[1:0]}];
    m_kl = Magic4[{col[3:2], row[3:2]}];
    t    = 15'd64 + 15'({m_ij, m_kl}) * 15'd127;
    return t[14:7];
  endfunction

  // One restoring division step: shift in a bit, subtract when it fits
  function automatic logic [DvsW:0] div_step(logic [DvsW-1:0] rem, logic bit_in,
                                             logic [DvsW-1:0] dvs);
    logic [DvsW:0] t;
    logic [DvsW:0] r;
    t = {rem, bit_in};
    r = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, r[DvsW-1:0]};
    end
    return {1'b0, t[DvsW-1:0]};
  endfunction

endpackage

// File: rtl/bdod_in_if.sv
// Input channel of the bilinear density dither: one grid point per request.
// Depends on bdod_pkg for field widths.
interface bdod_in_if;
  logic                           valid;
  logic                           ready;
  logic [bdod_pkg::PosW-1:0]      pos_x;
  logic [bdod_pkg::PosW-1:0]      pos_y;
  logic [bdod_pkg::ShiftW-1:0]    shift_x;
  logic [bdod_pkg::ShiftW-1:0]    shift_y;
  logic [bdod_pkg::AlphaW-1:0]    alpha_c0;
  logic [bdod_pkg::AlphaW-1:0]    alpha_c1;
  logic [bdod_pkg::AlphaW-1:0]    alpha_c2;
  logic [bdod_pkg::AlphaW-1:0]    alpha_c3;

  modport source (
    output valid, pos_x, pos_y, shift_x, shift_y,
           alpha_c0, alpha_c1, alpha_c2, alpha_c3,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, shift_x, shift_y,
           alpha_c0, alpha_c1, alpha_c2, alpha_c3,
    output ready
  );
endinterface

// File: rtl/bdod_out_if.sv
// Output channel of the bilinear density dither: level and coverage per request.
// Depends on bdod_pkg for field widths.
interface bdod_out_if;
  logic                        valid;
  logic                        ready;
  logic                        covered;
  logic [bdod_pkg::LevelW-1:0] level;

  modport source (output valid, covered, level, input ready);
  modport sink   (input valid, covered, level, output ready);
endinterface

// File: rtl/bdod_front.sv
// Front end: clamp, bilinear weights, corner products and the dividend sum.
// Four register stages; depends on bdod_pkg and bdod_in_if.
module bdod_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [bdod_pkg::PosW-1:0] grid_size_i,
  bdod_in_if.sink                   in_i,
  output logic                      dn_valid_o,
  input  logic                      dn_ready_i,
  output bdod_pkg::front_t          dn_o
);

  localparam int unsigned NStage = 4;

  typedef struct packed {
    logic [5:0] s;
    logic [5:0] xc;
    logic [5:0] yc;
    logic [5:0] wx;
    logic [5:0] wy;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] thr;
  } st0_t;

  typedef struct packed {
    logic [11:0] w00;
    logic [11:0] w10;
    logic [11:0] w01;
    logic [11:0] w11;
    logic [11:0] den;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  thr;
  } st1_t;

  typedef struct packed {
    logic [19:0] t0;
    logic [19:0] t1;
    logic [19:0] t2;
    logic [19:0] t3;
    logic [11:0] den;
    logic [7:0]  thr;
  } st2_t;

  logic [NStage-1:0] v_q;
  logic [NStage:0]   en;
  st0_t              s0_d, s0_q;
  st1_t              s1_d, s1_q;
  st2_t              s2_d, s2_q;
  bdod_pkg::front_t  s3_d, s3_q;
  logic [5:0]        s_eff;
  logic [5:0]        s_m1;
  logic [19:0]       num;

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NStage] = dn_ready_i;
    for (int k = NStage - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign in_i.ready = en[0];
  assign dn_valid_o = v_q[NStage-1];
  assign dn_o       = s3_q;

  // Stage 0: effective grid size, clamp, weights, scaled corners, threshold
  always_comb begin
    s_eff = (grid_size_i == '0) ? 6'd1 : grid_size_i;
    if (s_eff > bdod_pkg::MaxGrid) begin
      s_eff = bdod_pkg::MaxGrid;
    end
    s_m1    = s_eff - 6'd1;
    s0_d.s  = s_eff;
    s0_d.xc = (in_i.pos_x > s_m1) ? s_m1 : in_i.pos_x;
    s0_d.yc = (in_i.pos_y > s_m1) ? s_m1 : in_i.pos_y;
    s0_d.wx = s_eff - s0_d.xc;
    s0_d.wy = s_eff - s0_d.yc;
    // 17*a is the nibble repeated
    s0_d.b0 = {in_i.alpha_c0, in_i.alpha_c0};
    s0_d.b1 = {in_i.alpha_c1, in_i.alpha_c1};
    s0_d.b2 = {in_i.alpha_c2, in_i.alpha_c2};
    s0_d.b3 = {in_i.alpha_c3, in_i.alpha_c3};
    s0_d.thr = bdod_pkg::dither_thr(s0_d.xc[3:0] + in_i.shift_x,
                                    s0_d.yc[3:0] + in_i.shift_y);
  end

  // Stage 1: weight products and denominator
  always_comb begin
    s1_d.w00 = 12'(s0_q.wx) * 12'(s0_q.wy);
    s1_d.w10 = 12'(s0_q.xc) * 12'(s0_q.wy);
    s1_d.w01 = 12'(s0_q.wx) * 12'(s0_q.yc);
    s1_d.w11 = 12'(s0_q.xc) * 12'(s0_q.yc);
    s1_d.den = 12'(s0_q.s) * 12'(s0_q.s);
    s1_d.b0  = s0_q.b0;
    s1_d.b1  = s0_q.b1;
    s1_d.b2  = s0_q.b2;
    s1_d.b3  = s0_q.b3;
    s1_d.thr = s0_q.thr;
  end

  // Stage 2: weighted corner terms
  always_comb begin
    s2_d.t0  = 20'(s1_q.w00) * 20'(s1_q.b0);
    s2_d.t1  = 20'(s1_q.w10) * 20'(s1_q.b1);
    s2_d.t2  = 20'(s1_q.w01) * 20'(s1_q.b2);
    s2_d.t3  = 20'(s1_q.w11) * 20'(s1_q.b3);
    s2_d.den = s1_q.den;
    s2_d.thr = s1_q.thr;
  end

  // Stage 3: numerator sum, rounding offset, doubled divisor
  always_comb begin
    num      = s2_q.t0 + s2_q.t1 + s2_q.t2 + s2_q.t3;
    s3_d.dvd = {num, 1'b0} + 21'(s2_q.den);
    s3_d.dvs = {s2_q.den, 1'b0};
    s3_d.thr = s2_q.thr;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_i.valid;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en[0]) s0_q <= s0_d;
    if (en[1]) s1_q <= s1_d;
    if (en[2]) s2_q <= s2_d;
    if (en[3]) s3_q <= s3_d;
  end

endmodule

// File: rtl/bdod_div.sv
// Pipelined restoring divider: 8-bit quotient, two quotient bits per stage.
// Depends on bdod_pkg and the assertion macros header.
`include "bilinear_density_ordered_dither_defines.svh"

module bdod_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             up_valid_i,
  output logic             up_ready_o,
  input  bdod_pkg::front_t up_i,
  output logic             dn_valid_o,
  input  logic             dn_ready_i,
  output bdod_pkg::quot_t  dn_o
);

  localparam int unsigned NStage = 4;
  localparam int unsigned DvsW   = bdod_pkg::DvsW;
  localparam int unsigned LevelW = bdod_pkg::LevelW;

  typedef struct packed {
    logic [DvsW-1:0]   rem;
    logic [DvsW-1:0]   dvs;
    logic [LevelW-1:0] lo;   // dividend bits still to shift in
    logic [LevelW-1:0] quo;
    logic [LevelW-1:0] thr;
  } dst_t;

  logic [NStage-1:0] v_q;
  logic [NStage:0]   en;
  dst_t              st_d [NStage];
  dst_t              st_q [NStage];
  dst_t              src  [NStage];
  dst_t              entry;
  logic [DvsW:0]     step_a [NStage];
  logic [DvsW:0]     step_b [NStage];

  // Advance a stage when it is empty or the next one advances
  always_comb begin
    en[NStage] = dn_ready_i;
    for (int k = NStage - 1; k >= 0; k--) begin
      en[k] = ~v_q[k] | en[k+1];
    end
  end

  assign up_ready_o = en[0];
  assign dn_valid_o = v_q[NStage-1];
  assign dn_o.quo   = st_q[NStage-1].quo;
  assign dn_o.thr   = st_q[NStage-1].thr;

  // Quotient fits 8 bits, so the upper dividend bits start below the divisor
  always_comb begin
    entry.rem = up_i.dvd[bdod_pkg::DvdW-1:LevelW];
    entry.dvs = up_i.dvs;
    entry.lo  = up_i.dvd[LevelW-1:0];
    entry.quo = '0;
    entry.thr = up_i.thr;
  end

  // Two restoring steps per stage
  always_comb begin
    for (int k = 0; k < NStage; k++) begin
      src[k]       = (k == 0) ? entry : st_q[(k == 0) ? 0 : k - 1];
      step_a[k]    = bdod_pkg::div_step(src[k].rem, src[k].lo[LevelW-1], src[k].dvs);
      step_b[k]    = bdod_pkg::div_step(step_a[k][DvsW-1:0], src[k].lo[LevelW-2],
                                        src[k].dvs);
      st_d[k].rem  = step_b[k][DvsW-1:0];
      st_d[k].dvs  = src[k].dvs;
      st_d[k].lo   = {src[k].lo[LevelW-3:0], 2'b00};
      st_d[k].quo  = {src[k].quo[LevelW-3:0], step_a[k][DvsW], step_b[k][DvsW]};
      st_d[k].thr  = src[k].thr;
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= up_valid_i;
      for (int k = 1; k < NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NStage; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  `BDOD_ASSERT_IMPLY(a_dvs_nonzero, up_valid_i, up_i.dvs != '0, "divisor is zero")
  `BDOD_ASSERT_IMPLY(a_rem_below_dvs, v_q[NStage-1], st_q[NStage-1].rem < st_q[NStage-1].dvs, "remainder not below divisor")
  `BDOD_ASSERT_NEXT(a_hold_on_stall, v_q[NStage-1] && !dn_ready_i, v_q[NStage-1] && $stable(st_q[NStage-1].quo), "last stage lost its request under stall")

endmodule

// File: rtl/bilinear_density_ordered_dither.sv
// Top level of the bilinear density dither: config register, pipeline, output register.
// Depends on bdod_pkg, bdod_in_if, bdod_out_if, bdod_front and bdod_div.
//
// Usage:
//   in_i carries one grid point per request (position, dither shift, four corner
//   densities); out_o returns one result per request, in order: the rounded
//   bilinear level and whether it exceeds the ordered dither threshold.
//   cfg_we_i/cfg_wdata_i write grid_size; write it only while no request is in flight.
// Pipeline: nine register stages from input acceptance to output valid (four
//   front-end, four divider and one output register; the accepting edge
//   loads the first of them).
// Throughput: one request per cycle while out_o is not held off; every stage holds
//   one request and the divider retires two quotient bits per stage.
// Reset: clears all valid bits, sets grid_size to 10; in_i is ready right away.
// Stall: when out_o is held off the result waits in the output register while
//   the pipeline keeps filling its empty stages; in_i drops ready only once
//   every stage is occupied. Nothing is lost or repeated.
module bilinear_density_ordered_dither (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [bdod_pkg::PosW-1:0] cfg_wdata_i,
  bdod_in_if.sink                   in_i,
  bdod_out_if.source                out_o
);

  logic [bdod_pkg::PosW-1:0]   grid_size_q;
  logic                        fr_valid;
  logic                        fr_ready;
  bdod_pkg::front_t            fr_data;
  logic                        dv_valid;
  logic                        out_en;
  bdod_pkg::quot_t             dv_data;
  logic                        out_v_q;
  logic                        covered_q;
  logic [bdod_pkg::LevelW-1:0] level_q;

  // Grid size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= bdod_pkg::GridReset;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  bdod_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grid_size_i (grid_size_q),
    .in_i        (in_i),
    .dn_valid_o  (fr_valid),
    .dn_ready_i  (fr_ready),
    .dn_o        (fr_data)
  );

  bdod_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (fr_valid),
    .up_ready_o (fr_ready),
    .up_i       (fr_data),
    .dn_valid_o (dv_valid),
    .dn_ready_i (out_en),
    .dn_o       (dv_data)
  );

  // Load the output register when it is empty or being drained
  assign out_en = ~out_v_q | out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= dv_valid;
    end
  end

  // Compare the level against the dither threshold
  always_ff @(posedge clk_i) begin
    if (out_en) begin
      level_q   <= dv_data.quo;
      covered_q <= dv_data.quo > dv_data.thr;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.covered = covered_q;
  assign out_o.level   = level_q;

endmodule
